>>> sv/lpsc_pkg.sv
package lpsc_pkg;

	// parser phases of one line
	typedef enum logic [1:0] {
		PH_BLANKS,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE
	} parse_phase_t;

	// configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_LINE_CENTER = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD  = 1'd1;
	localparam int CFG_DATA_W = 12;

	// defaults
	localparam int LINE_CHARS_MAX_DEF = 100;
	localparam logic [9:0]  LINE_CENTER_RST = 10'd320;
	localparam logic [11:0] PWM_PERIOD_RST  = 12'd1200;

	// character codes
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// parse limits
	localparam logic [14:0] ACC_MAX = 15'd32767;

	// control law constants
	localparam logic [16:0] ERR_SMALL = 17'd50;
	localparam logic [16:0] ERR_MID   = 17'd150;
	localparam logic signed [15:0] POS_LOW  = 16'sd50;
	localparam logic signed [15:0] POS_HIGH = 16'sd590;
	localparam logic [9:0] LVP_LEFT_LIM  = 10'd300;
	localparam logic [9:0] LVP_RIGHT_LIM = 10'd340;
	localparam logic signed [15:0] PIVOT_DUTY = 16'sd800;

	// divide by three: q = (m * RECIP3) >> RECIP3_SHIFT, exact for m < 2**17
	localparam int RECIP3_SHIFT = 18;
	localparam logic [17:0] RECIP3 = 18'd87382;

	// steering result of one update: duties, lost flag and last valid position update
	typedef struct packed {
		logic signed [15:0] left_duty;
		logic signed [15:0] right_duty;
		logic               lost;
		logic               lvp_upd;
		logic [9:0]         lvp_next;
	} steer_res_t;

	function automatic logic is_line_end(input logic [7:0] c);
		return (c == CHAR_CR) || (c == CHAR_LF);
	endfunction

endpackage

>>> sv/lpsc_parser.sv
module lpsc_parser #(
	parameter int LINE_CHARS_MAX = lpsc_pkg::LINE_CHARS_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte_s1,
	output logic signed [15:0] line_pos
);

	localparam int CNT_W = $clog2(LINE_CHARS_MAX + 1);

	lpsc_pkg::parse_phase_t phase_q, phase_n;
	logic               neg_q, neg_n;
	logic [14:0]        acc_q, acc_n;
	logic               seen_q, seen_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic signed [15:0] last_pos_q, last_pos_n;

	logic        term;
	logic        is_digit;
	logic        is_blank;
	logic        is_sign;
	logic [18:0] acc_wide;
	logic [14:0] acc_sat;
	logic [15:0] acc_ext;

	// character classes
	assign term     = lpsc_pkg::is_line_end(rx_byte_s1);
	assign is_digit = (rx_byte_s1 >= lpsc_pkg::CHAR_ZERO) && (rx_byte_s1 <= lpsc_pkg::CHAR_NINE);
	assign is_blank = rx_byte_s1 inside {lpsc_pkg::CHAR_SPACE, lpsc_pkg::CHAR_TAB,
		lpsc_pkg::CHAR_VT, lpsc_pkg::CHAR_FF};
	assign is_sign  = rx_byte_s1 inside {lpsc_pkg::CHAR_PLUS, lpsc_pkg::CHAR_MINUS};

	// accumulator times ten plus digit, saturated
	assign acc_wide = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {15'd0, rx_byte_s1[3:0]};
	assign acc_sat  = (acc_wide > {4'd0, lpsc_pkg::ACC_MAX}) ? lpsc_pkg::ACC_MAX : acc_wide[14:0];

	// position of the line so far, or the kept one
	assign acc_ext  = {1'b0, acc_q};
	assign line_pos = !seen_q ? last_pos_q :
		(neg_q ? $signed(16'd0 - acc_ext) : $signed(acc_ext));

	// next state
	always_comb begin
		phase_n    = phase_q;
		neg_n      = neg_q;
		acc_n      = acc_q;
		seen_n     = seen_q;
		cnt_n      = cnt_q;
		last_pos_n = last_pos_q;
		if (step) begin
			if (term) begin
				last_pos_n = line_pos;
				phase_n    = lpsc_pkg::PH_BLANKS;
				neg_n      = 1'b0;
				acc_n      = '0;
				seen_n     = 1'b0;
				cnt_n      = '0;
			end else if (cnt_q < CNT_W'(LINE_CHARS_MAX)) begin
				cnt_n = cnt_q + 1'b1;
				if (rx_byte_s1 == lpsc_pkg::CHAR_NUL) begin
					phase_n = lpsc_pkg::PH_DONE;
				end else begin
					unique case (phase_q)
						lpsc_pkg::PH_BLANKS: begin
							if (is_blank) begin
								phase_n = phase_q;
							end else if (is_sign) begin
								neg_n   = (rx_byte_s1 == lpsc_pkg::CHAR_MINUS);
								phase_n = lpsc_pkg::PH_SIGN;
							end else if (is_digit) begin
								acc_n   = acc_sat;
								seen_n  = 1'b1;
								phase_n = lpsc_pkg::PH_DIGITS;
							end else begin
								phase_n = lpsc_pkg::PH_DONE;
							end
						end
						lpsc_pkg::PH_SIGN, lpsc_pkg::PH_DIGITS: begin
							if (is_digit) begin
								acc_n   = acc_sat;
								seen_n  = 1'b1;
								phase_n = lpsc_pkg::PH_DIGITS;
							end else begin
								phase_n = lpsc_pkg::PH_DONE;
							end
						end
						lpsc_pkg::PH_DONE: begin
							phase_n = phase_q;
						end
						default: begin
							phase_n = lpsc_pkg::PH_DONE;
						end
					endcase
				end
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lpsc_pkg::PH_BLANKS;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			seen_q     <= 1'b0;
			cnt_q      <= '0;
			last_pos_q <= '0;
		end else begin
			phase_q    <= phase_n;
			neg_q      <= neg_n;
			acc_q      <= acc_n;
			seen_q     <= seen_n;
			cnt_q      <= cnt_n;
			last_pos_q <= last_pos_n;
		end
	end

	// character count never runs past the line limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LINE_CHARS_MAX))
		else $error("line character count beyond limit");

	// digits only exist once the parser has reached the digit phase
	a_seen_phase: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (phase_q == lpsc_pkg::PH_DIGITS) || (phase_q == lpsc_pkg::PH_DONE))
		else $error("digits seen in a phase before digits");

	// a terminator clears the line state
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && term |=> !seen_q && !neg_q && (cnt_q == '0) && (acc_q == '0))
		else $error("line state not cleared after terminator");

endmodule

>>> sv/lpsc_steer.sv
module lpsc_steer (
	input  logic signed [15:0]   pos,
	input  logic [9:0]           line_center,
	input  logic [11:0]          pwm_period,
	input  logic [9:0]           last_valid,
	output lpsc_pkg::steer_res_t res
);

	logic signed [16:0] err;
	logic [16:0]        mag;
	logic signed [18:0] e19;
	logic signed [18:0] ref4;
	logic signed [18:0] ref3;
	logic signed [18:0] five;
	logic signed [18:0] ref_half;
	logic signed [18:0] ref_wide;
	logic signed [17:0] ref_val;
	logic signed [17:0] num;
	logic [16:0]        nmag;
	logic [34:0]        prod;
	logic [16:0]        quo_mag;
	logic signed [17:0] quot;
	logic signed [15:0] half_per;
	logic               ref_pos;
	logic               off_line;

	// error and its magnitude
	assign err = {pos[15], pos} - $signed({7'd0, line_center});
	assign mag = err[16] ? 17'(-err) : err;
	assign e19 = {{2{err[16]}}, err};

	// gain by error band; 2.5x truncates toward zero
	assign ref4     = e19 <<< 2;
	assign ref3     = (e19 <<< 1) + e19;
	assign five     = (e19 <<< 2) + e19;
	assign ref_half = (five + {18'd0, five[18]}) >>> 1;

	always_comb begin
		if (mag != '0 && mag < lpsc_pkg::ERR_SMALL) begin
			ref_wide = ref4;
		end else if (mag != '0 && mag < lpsc_pkg::ERR_MID) begin
			ref_wide = ref3;
		end else begin
			ref_wide = ref_half;
		end
	end
	assign ref_val = ref_wide[17:0];
	assign ref_pos = !ref_val[17] && (ref_val != '0);

	// (period - ref) / 3 toward zero by reciprocal multiply
	assign num      = $signed({6'd0, pwm_period}) - ref_val;
	assign nmag     = num[17] ? 17'(-num) : num[16:0];
	assign prod     = nmag * lpsc_pkg::RECIP3;
	assign quo_mag  = prod[34:lpsc_pkg::RECIP3_SHIFT];
	assign quot     = num[17] ? $signed(18'd0 - {1'b0, quo_mag}) : $signed({1'b0, quo_mag});
	assign half_per = $signed({5'd0, pwm_period[11:1]});

	// proportional duties and lost line pivot
	assign off_line = (pos < lpsc_pkg::POS_LOW) || (pos > lpsc_pkg::POS_HIGH);

	always_comb begin
		if (ref_pos) begin
			res.left_duty  = half_per;
			res.right_duty = quot[15:0];
		end else begin
			res.left_duty  = quot[15:0];
			res.right_duty = half_per;
		end
		res.lost = 1'b0;
		if (off_line) begin
			if (last_valid < lpsc_pkg::LVP_LEFT_LIM) begin
				res.left_duty  = '0;
				res.right_duty = lpsc_pkg::PIVOT_DUTY;
				res.lost       = 1'b1;
			end else if (last_valid > lpsc_pkg::LVP_RIGHT_LIM) begin
				res.left_duty  = lpsc_pkg::PIVOT_DUTY;
				res.right_duty = '0;
				res.lost       = 1'b1;
			end
		end
		res.lvp_upd  = (pos > lpsc_pkg::POS_LOW) && (pos < lpsc_pkg::POS_HIGH);
		res.lvp_next = pos[9:0];
	end

endmodule

>>> sv/line_position_steering_controller.sv
// line position steering controller
// a terminating byte reaches the output through the input, line position and result registers
// throughput: one byte per cycle; a stall reaches the input only when a
// terminator meets a full parse-to-output path
// reset: parser, kept positions and valids clear; line_center 320, pwm_period 1200
module line_position_steering_controller #(
	parameter int LINE_CHARS_MAX = lpsc_pkg::LINE_CHARS_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                position,
	output logic signed [15:0]                left_duty,
	output logic signed [15:0]                right_duty,
	output logic                              lost_override,
	input  logic                              cfg_we,
	input  logic [lpsc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [lpsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic               valid_s1;
	logic [7:0]         rx_byte_s1;
	logic               valid_s2;
	logic signed [15:0] pos_s2;
	logic               out_valid_q;
	logic signed [15:0] pos_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic               lost_q;
	logic [9:0]         line_center_q;
	logic [11:0]        pwm_period_q;
	logic [9:0]         lvp_q;

	logic               term_s1;
	logic               out_free;
	logic               s2_free;
	logic               s1_go;
	logic               in_xfer;
	logic signed [15:0] line_pos;
	lpsc_pkg::steer_res_t res;

	// flow control
	assign term_s1  = lpsc_pkg::is_line_end(rx_byte_s1);
	assign out_free = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_go    = valid_s1 && (!term_s1 || s2_free);
	assign in_ready = !valid_s1 || s1_go;
	assign in_xfer  = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_center_q <= lpsc_pkg::LINE_CENTER_RST;
			pwm_period_q  <= lpsc_pkg::PWM_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpsc_pkg::REG_LINE_CENTER: line_center_q <= cfg_wdata[9:0];
				lpsc_pkg::REG_PWM_PERIOD:  pwm_period_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// character parser
	lpsc_parser #(
		.LINE_CHARS_MAX(LINE_CHARS_MAX)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_go),
		.rx_byte_s1(rx_byte_s1),
		.line_pos  (line_pos)
	);

	// finished line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && term_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && term_s1) begin
			pos_s2 <= line_pos;
		end
	end

	// steering law
	lpsc_steer u_steer (
		.pos        (pos_s2),
		.line_center(line_center_q),
		.pwm_period (pwm_period_q),
		.last_valid (lvp_q),
		.res        (res)
	);

	// result register and last valid position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			lvp_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
			if (valid_s2 && out_free && res.lvp_upd) begin
				lvp_q <= res.lvp_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			pos_q   <= pos_s2;
			left_q  <= res.left_duty;
			right_q <= res.right_duty;
			lost_q  <= res.lost;
		end
	end

	assign out_valid     = out_valid_q;
	assign position      = pos_q;
	assign left_duty     = left_q;
	assign right_duty    = right_q;
	assign lost_override = lost_q;

	// a non-terminating byte never holds up the input
	a_no_stall_plain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !term_s1 |-> in_ready)
		else $error("input stalled on a non-terminating byte");

	// a blocked line position holds until the result register frees
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(pos_s2))
		else $error("line position lost while output stalled");

	// the override only ever drives one of the two pivots
	a_pivot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && lost_q |->
			(left_q == 16'sd0 && right_q == lpsc_pkg::PIVOT_DUTY) ||
			(left_q == lpsc_pkg::PIVOT_DUTY && right_q == 16'sd0))
		else $error("lost line override with non-pivot duties");

endmodule
